[src/dne_pkg.sv]
// dne_pkg: shared types and constants for the decimal number entry block
// character codes, sequencer states, accumulator width and int32 limits
// no dependencies
`default_nettype none

package dne_pkg;

	// character codes
	localparam logic [7:0] KEY_BS    = 8'd8;
	localparam logic [7:0] KEY_LF    = 8'd10;
	localparam logic [7:0] KEY_CR    = 8'd13;
	localparam logic [7:0] KEY_MINUS = 8'd45;
	localparam logic [7:0] KEY_ZERO  = 8'd48;
	localparam logic [7:0] KEY_NINE  = 8'd57;

	// result kinds
	localparam logic KIND_ECHO   = 1'b0;
	localparam logic KIND_NUMBER = 1'b1;

	// register indexes
	localparam logic REG_MAX_DIGITS = 1'b0;
	localparam logic REG_SATURATE   = 1'b1;

	// eleven decimal digits fit in 37 bits
	localparam int unsigned ACC_W = 37;

	localparam logic [ACC_W-1:0] POS_LIMIT = 37'd2147483647;
	localparam logic [ACC_W-1:0] NEG_LIMIT = 37'd2147483648;
	localparam logic [31:0]      INT_MAX_BITS = 32'h7FFF_FFFF;
	localparam logic [31:0]      INT_MIN_BITS = 32'h8000_0000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_PRIME,
		ST_MAC,
		ST_FINISH
	} state_t;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_BACK,
		ACT_MINUS,
		ACT_DIGIT,
		ACT_CONVERT
	} action_t;

	// control from the sequencer to the accumulate unit
	typedef struct packed {
		logic clear;
		logic step;
	} mac_ctrl_t;

endpackage

`default_nettype wire

[src/dne_ram.sv]
// dne_ram: generic single-write, single-read RAM with registered read data
// no dependencies
`default_nettype none

module dne_ram #(
	parameter int unsigned WIDTH = 4,
	parameter int unsigned DEPTH = 11
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[src/dne_mac.sv]
// dne_mac: shared multiply-by-ten-and-add accumulator with int32 finishing
// (wrap or saturate, then sign); depends on dne_pkg
`default_nettype none

module dne_mac import dne_pkg::*; (
	input  wire logic         clk,
	input  wire mac_ctrl_t    ctrl,
	input  wire logic [3:0]   digit,
	input  wire logic         negative,
	input  wire logic         saturate,
	output logic signed [31:0] value
);

	logic [ACC_W-1:0] acc_q;
	logic [31:0]      low;

	// acc * 10 as (acc << 3) + (acc << 1)
	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			acc_q <= '0;
		end else if (ctrl.step) begin
			acc_q <= (acc_q << 3) + (acc_q << 1) + ACC_W'(digit);
		end
	end

	always_comb begin
		low = acc_q[31:0];
		if (saturate && !negative && acc_q > POS_LIMIT) begin
			value = INT_MAX_BITS;
		end else if (saturate && negative && acc_q > NEG_LIMIT) begin
			value = INT_MIN_BITS;
		end else if (negative) begin
			value = 32'd0 - low;
		end else begin
			value = low;
		end
	end

endmodule

`default_nettype wire

[src/decimal_number_entry.sv]
// decimal_number_entry: top level of the line-edited signed decimal entry block
// depends on dne_pkg, dne_ram (digit store) and dne_mac (shared accumulator)
`default_nettype none

// Characters come in one item at a time on key_*, and results leave on
// result_* through a single output register. Digits are kept in a small RAM,
// a leading minus sets the sign, backspace deletes the last character, and
// every character that changes the line is echoed as an item with
// result_kind 0. Enter on a non-empty line runs the stored digits through one
// shared multiply-by-ten accumulator, one digit per cycle, then wraps or clamps
// to int32 depending on the saturate register and sends the value with
// result_kind 1. The block takes one item at a time: it does not accept the
// next character until it is done with the last. Enter passes through a
// priming state for the registered RAM read and then the per-digit accumulate
// loop, which a lone minus skips along with the digit read. A result that is
// not taken holds the sequencer until the output register frees up. max_digits
// is clamped to 1..DIGIT_CAPACITY; lowering it mid-line keeps the digits
// already stored.
module decimal_number_entry import dne_pkg::*; #(
	parameter int unsigned DIGIT_CAPACITY = 11
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [3:0]  cfg_data,
	// character items
	input  wire logic        key_valid,
	output logic             key_ready,
	input  wire logic [7:0]  key_char,
	// result items
	output logic             result_valid,
	input  wire logic        result_ready,
	output logic             result_kind,
	output logic [7:0]       echo_char,
	output logic signed [31:0] number_value
);

	localparam int unsigned LEN_W  = $clog2(DIGIT_CAPACITY + 1);
	localparam int unsigned ADDR_W = DIGIT_CAPACITY > 1 ? $clog2(DIGIT_CAPACITY) : 1;
	localparam logic [3:0]  CAP4   = 4'(DIGIT_CAPACITY);

	state_t            state_q, state_d;
	action_t           act;
	mac_ctrl_t         mac_ctrl;

	logic [3:0]        max_digits_q;
	logic              saturate_q;
	logic [7:0]        key_q;
	logic [LEN_W-1:0]  len_q;
	logic              minus_q;
	logic [LEN_W-1:0]  pos_q;

	logic              result_valid_q;
	logic              result_kind_q;
	logic [7:0]        echo_char_q;
	logic signed [31:0] number_value_q;

	logic              empty;
	logic [3:0]        limit;
	logic              is_digit;
	logic              out_free;
	logic              echo_load;
	logic              num_load;
	logic              store_we;
	logic              pos_clr;
	logic              pos_inc;
	logic [ADDR_W-1:0] rd_addr;
	logic [3:0]        rd_digit;
	logic signed [31:0] mac_value;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_digits_q <= 4'd11;
			saturate_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAX_DIGITS: max_digits_q <= cfg_data;
				REG_SATURATE:   saturate_q   <= cfg_data[0];
				default:        max_digits_q <= max_digits_q;
			endcase
		end
	end

	// effective digit limit, clamped to 1..capacity
	always_comb begin
		if (max_digits_q > CAP4) begin
			limit = CAP4;
		end else if (max_digits_q == 4'd0) begin
			limit = 4'd1;
		end else begin
			limit = max_digits_q;
		end
	end

	assign empty    = (len_q == '0) && !minus_q;
	assign is_digit = (key_q >= KEY_ZERO) && (key_q <= KEY_NINE);
	assign out_free = !result_valid_q || result_ready;

	// what the held character does to the line
	always_comb begin
		priority if (key_q == KEY_LF || key_q == KEY_CR) begin
			act = empty ? ACT_NONE : ACT_CONVERT;
		end else if (key_q == KEY_BS) begin
			act = empty ? ACT_NONE : ACT_BACK;
		end else if (key_q == KEY_MINUS) begin
			act = empty ? ACT_MINUS : ACT_NONE;
		end else if (is_digit && (4'(len_q) < limit)) begin
			act = ACT_DIGIT;
		end else begin
			act = ACT_NONE;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (key_valid) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				unique case (act)
					ACT_NONE:    state_d = ST_IDLE;
					ACT_CONVERT: state_d = (len_q == '0) ? ST_FINISH : ST_PRIME;
					default:     state_d = out_free ? ST_IDLE : ST_EVAL;
				endcase
			end
			ST_PRIME: state_d = ST_MAC;
			ST_MAC: begin
				if (pos_q == len_q) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		key_ready      = (state_q == ST_IDLE);
		mac_ctrl.clear = (state_q == ST_EVAL) && (act == ACT_CONVERT);
		mac_ctrl.step  = (state_q == ST_MAC);
		echo_load      = (state_q == ST_EVAL) && out_free
			&& (act == ACT_BACK || act == ACT_MINUS || act == ACT_DIGIT);
		store_we       = (state_q == ST_EVAL) && out_free && (act == ACT_DIGIT);
		num_load       = (state_q == ST_FINISH) && out_free;
		pos_clr        = mac_ctrl.clear;
		pos_inc        = (state_q == ST_PRIME) || (state_q == ST_MAC);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// held character
	always_ff @(posedge clk) begin
		if (key_valid && key_ready) begin
			key_q <= key_char;
		end
	end

	// line state: digit count and sign
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			minus_q <= 1'b0;
		end else if (num_load) begin
			len_q   <= '0;
			minus_q <= 1'b0;
		end else if (echo_load) begin
			unique case (act)
				ACT_DIGIT: len_q <= len_q + 1'b1;
				ACT_MINUS: minus_q <= 1'b1;
				ACT_BACK: begin
					if (len_q != '0) begin
						len_q <= len_q - 1'b1;
					end else begin
						minus_q <= 1'b0;
					end
				end
				default: len_q <= len_q;
			endcase
		end
	end

	// read pointer; the RAM runs one digit ahead of the accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (pos_clr) begin
			pos_q <= '0;
		end else if (pos_inc) begin
			pos_q <= pos_q + 1'b1;
		end
	end

	assign rd_addr = (pos_q < LEN_W'(DIGIT_CAPACITY)) ? pos_q[ADDR_W-1:0] : '0;

	dne_ram #(
		.WIDTH(4),
		.DEPTH(DIGIT_CAPACITY)
	) u_digits (
		.clk  (clk),
		.we   (store_we),
		.waddr(len_q[ADDR_W-1:0]),
		.wdata(key_q[3:0]),
		.raddr(rd_addr),
		.rdata(rd_digit)
	);

	dne_mac u_mac (
		.clk     (clk),
		.ctrl    (mac_ctrl),
		.digit   (rd_digit),
		.negative(minus_q),
		.saturate(saturate_q),
		.value   (mac_value)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (num_load || echo_load) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (num_load) begin
			result_kind_q  <= KIND_NUMBER;
			echo_char_q    <= 8'd0;
			number_value_q <= mac_value;
		end else if (echo_load) begin
			result_kind_q  <= KIND_ECHO;
			echo_char_q    <= key_q;
			number_value_q <= 32'sd0;
		end
	end

	assign result_valid = result_valid_q;
	assign result_kind  = result_kind_q;
	assign echo_char    = echo_char_q;
	assign number_value = number_value_q;

endmodule

`default_nettype wire

[src/dne_checker.sv]
// dne_checker: port-level assertions for decimal_number_entry, bound to the top
// depends on dne_pkg for the character codes and result kinds
`default_nettype none

module dne_checker import dne_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        key_valid,
	input wire logic        key_ready,
	input wire logic        result_valid,
	input wire logic        result_ready,
	input wire logic        result_kind,
	input wire logic [7:0]  echo_char,
	input wire logic [31:0] number_value
);

	// one item at a time: key_ready drops after each accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		key_valid && key_ready |=> !key_ready)
		else $error("key accepted on back-to-back cycles");

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_kind)
			&& $stable(echo_char) && $stable(number_value))
		else $error("stalled result changed");

	// the unused field of each result kind reads zero
	a_unused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result_kind == KIND_ECHO && number_value == 32'd0)
			|| (result_kind == KIND_NUMBER && echo_char == 8'd0))
		else $error("unused result field not zero");

	// only backspace, minus and digits are ever echoed
	a_echo_set: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_kind == KIND_ECHO |-> echo_char == KEY_BS
			|| echo_char == KEY_MINUS
			|| (echo_char >= KEY_ZERO && echo_char <= KEY_NINE))
		else $error("unexpected echoed character");

endmodule

bind decimal_number_entry dne_checker u_dne_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.key_valid   (key_valid),
	.key_ready   (key_ready),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.result_kind (result_kind),
	.echo_char   (echo_char),
	.number_value(number_value)
);

`default_nettype wire
